### rtl/ksr_pkg.sv
// Shared types and constants of the key sequence remapper.
package ksr_pkg;

    // Kind of input request, carried on s_tuser
    typedef enum logic [1:0] {
        OP_KEY  = 2'd0,
        OP_TICK = 2'd1,
        OP_BYTE = 2'd2,
        OP_HDR  = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic REG_MAP_COUNT = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    // Timeout after reset, in frame ticks
    localparam logic [7:0] DEFAULT_TIMEOUT = 8'd60;

    // Table access strobes from the controller to the table memories
    typedef struct packed {
        logic we_left;
        logic we_right;
        logic we_hdr;
        logic rd_scan;
        logic rd_right;
    } tbl_cmd_t;

endpackage

### rtl/key_sequence_remapper.sv
// Top level of the key sequence remapper: stream ports, configuration and instances.
//
// Every request is taken one at a time, only while the sequencer is idle. Table byte
// writes, entry header writes and frame ticks are taken in the idle state; a tick that
// expires the timeout starts a flush. A key press scans the live mapping entries in
// table order, each entry by a read of the entry header and left-side row from the
// table memory followed by a compare of the row with the held keys in parallel, after
// which a match plays its right side with one read of the right-side memory per key,
// and a flush hands on the held keys one at a time. Results wait in an output register, and the
// next request is taken while the final result of a run is still waiting there.
// The table memories are not cleared: entries must be written before map_count
// covers them.
module key_sequence_remapper #(
    parameter int MAP_ENTRIES = 16,
    parameter int LEFT_MAX    = 8,
    parameter int RIGHT_MAX   = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    // key_value[7:0], key_mode[8], entry_index[12:9], byte_position[17:13],
    // byte_is_right[18], table_byte[26:19], left_length[30:27],
    // right_length[35:31], entry_mode[36], zero fill[39:37]
    input  logic [39:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    // result requests
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_key[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int EW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int LW  = (LEFT_MAX > 1) ? $clog2(LEFT_MAX) : 1;
    localparam int RW  = (RIGHT_MAX > 1) ? $clog2(RIGHT_MAX) : 1;
    localparam int LLW = $clog2(LEFT_MAX + 1);
    localparam int RLW = $clog2(RIGHT_MAX + 1);

    logic [4:0]               map_count_reg;
    logic [7:0]               timeout_ticks_reg;

    ksr_pkg::tbl_cmd_t        cmd;
    logic [EW-1:0]            wr_entry;
    logic [LW-1:0]            wr_lpos;
    logic [RW-1:0]            wr_rpos;
    logic [7:0]               wr_byte;
    logic [LLW-1:0]           wr_llen;
    logic [RLW-1:0]           wr_rlen;
    logic                     wr_mode;
    logic [EW-1:0]            rd_entry;
    logic [RW-1:0]            rd_rpos;
    logic [LEFT_MAX-1:0][7:0] left_row;
    logic [LLW-1:0]           hdr_llen;
    logic [RLW-1:0]           hdr_rlen;
    logic                     hdr_mode;
    logic [7:0]               right_byte;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_count_reg     <= '0;
            timeout_ticks_reg <= ksr_pkg::DEFAULT_TIMEOUT;
        end else if (cfg_we) begin
            if (cfg_addr == ksr_pkg::REG_MAP_COUNT) begin
                map_count_reg <= cfg_wdata[4:0];
            end
            if (cfg_addr == ksr_pkg::REG_TIMEOUT) begin
                timeout_ticks_reg <= cfg_wdata;
            end
        end
    end

    ksr_ctrl #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .LEFT_MAX    (LEFT_MAX),
        .RIGHT_MAX   (RIGHT_MAX)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .op            (ksr_pkg::op_t'(s_tuser)),
        .key_value     (s_tdata[7:0]),
        .key_mode      (s_tdata[8]),
        .entry_index   (s_tdata[12:9]),
        .byte_position (s_tdata[17:13]),
        .byte_is_right (s_tdata[18]),
        .table_byte    (s_tdata[26:19]),
        .left_length   (s_tdata[30:27]),
        .right_length  (s_tdata[35:31]),
        .entry_mode    (s_tdata[36]),
        .map_count     (map_count_reg),
        .timeout_ticks (timeout_ticks_reg),
        .cmd           (cmd),
        .wr_entry      (wr_entry),
        .wr_lpos       (wr_lpos),
        .wr_rpos       (wr_rpos),
        .wr_byte       (wr_byte),
        .wr_llen       (wr_llen),
        .wr_rlen       (wr_rlen),
        .wr_mode       (wr_mode),
        .rd_entry      (rd_entry),
        .rd_rpos       (rd_rpos),
        .left_row      (left_row),
        .hdr_llen      (hdr_llen),
        .hdr_rlen      (hdr_rlen),
        .hdr_mode      (hdr_mode),
        .right_byte    (right_byte),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_key         (m_tdata),
        .m_last        (m_tlast)
    );

    ksr_table #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .LEFT_MAX    (LEFT_MAX),
        .RIGHT_MAX   (RIGHT_MAX)
    ) u_table (
        .aclk       (aclk),
        .cmd        (cmd),
        .wr_entry   (wr_entry),
        .wr_lpos    (wr_lpos),
        .wr_rpos    (wr_rpos),
        .wr_byte    (wr_byte),
        .wr_llen    (wr_llen),
        .wr_rlen    (wr_rlen),
        .wr_mode    (wr_mode),
        .rd_entry   (rd_entry),
        .rd_rpos    (rd_rpos),
        .left_row   (left_row),
        .hdr_llen   (hdr_llen),
        .hdr_rlen   (hdr_rlen),
        .hdr_mode   (hdr_mode),
        .right_byte (right_byte)
    );

endmodule

### rtl/ksr_table.sv
// Mapping table memories: left-side rows, entry headers and right-side bytes.
module ksr_table #(
    parameter int MAP_ENTRIES = 16,
    parameter int LEFT_MAX    = 8,
    parameter int RIGHT_MAX   = 24,
    localparam int EW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1,
    localparam int LW  = (LEFT_MAX > 1) ? $clog2(LEFT_MAX) : 1,
    localparam int RW  = (RIGHT_MAX > 1) ? $clog2(RIGHT_MAX) : 1,
    localparam int LLW = $clog2(LEFT_MAX + 1),
    localparam int RLW = $clog2(RIGHT_MAX + 1)
) (
    input  logic                         aclk,
    input  ksr_pkg::tbl_cmd_t            cmd,
    input  logic [EW-1:0]                wr_entry,
    input  logic [LW-1:0]                wr_lpos,
    input  logic [RW-1:0]                wr_rpos,
    input  logic [7:0]                   wr_byte,
    input  logic [LLW-1:0]               wr_llen,
    input  logic [RLW-1:0]               wr_rlen,
    input  logic                         wr_mode,
    input  logic [EW-1:0]                rd_entry,
    input  logic [RW-1:0]                rd_rpos,
    output logic [LEFT_MAX-1:0][7:0]     left_row,
    output logic [LLW-1:0]               hdr_llen,
    output logic [RLW-1:0]               hdr_rlen,
    output logic                         hdr_mode,
    output logic [7:0]                   right_byte
);

    localparam int HW  = 1 + RLW + LLW;

    logic [LEFT_MAX-1:0][7:0] left_mem [MAP_ENTRIES];
    logic [HW-1:0]            hdr_mem  [MAP_ENTRIES];
    logic [7:0]               right_mem [MAP_ENTRIES][RIGHT_MAX];

    logic [LEFT_MAX-1:0][7:0] left_row_reg;
    logic [HW-1:0]            hdr_reg;
    logic [7:0]               right_byte_reg;

    // Left sides: byte write, whole-row read for the parallel compare
    always_ff @(posedge aclk) begin
        if (cmd.we_left) begin
            left_mem[wr_entry][wr_lpos] <= wr_byte;
        end
        if (cmd.rd_scan) begin
            left_row_reg <= left_mem[rd_entry];
        end
    end

    // Entry headers: mode and both lengths, read alongside the left row
    always_ff @(posedge aclk) begin
        if (cmd.we_hdr) begin
            hdr_mem[wr_entry] <= {wr_mode, wr_rlen, wr_llen};
        end
        if (cmd.rd_scan) begin
            hdr_reg <= hdr_mem[rd_entry];
        end
    end

    // Right sides: one byte per cycle in each direction
    always_ff @(posedge aclk) begin
        if (cmd.we_right) begin
            right_mem[wr_entry][wr_rpos] <= wr_byte;
        end
        if (cmd.rd_right) begin
            right_byte_reg <= right_mem[rd_entry][rd_rpos];
        end
    end

    assign left_row   = left_row_reg;
    assign hdr_llen   = hdr_reg[LLW-1:0];
    assign hdr_rlen   = hdr_reg[LLW +: RLW];
    assign hdr_mode   = hdr_reg[HW-1];
    assign right_byte = right_byte_reg;

endmodule

### rtl/ksr_ctrl.sv
// Request sequencer: pending buffer, table scan, timeout and output register.
module ksr_ctrl #(
    parameter int MAP_ENTRIES = 16,
    parameter int LEFT_MAX    = 8,
    parameter int RIGHT_MAX   = 24,
    localparam int EW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1,
    localparam int LW  = (LEFT_MAX > 1) ? $clog2(LEFT_MAX) : 1,
    localparam int LLW = $clog2(LEFT_MAX + 1),
    localparam int RW  = (RIGHT_MAX > 1) ? $clog2(RIGHT_MAX) : 1,
    localparam int RLW = $clog2(RIGHT_MAX + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input requests
    input  logic                     s_valid,
    output logic                     s_ready,
    input  ksr_pkg::op_t             op,
    input  logic [7:0]               key_value,
    input  logic                     key_mode,
    input  logic [3:0]               entry_index,
    input  logic [4:0]               byte_position,
    input  logic                     byte_is_right,
    input  logic [7:0]               table_byte,
    input  logic [3:0]               left_length,
    input  logic [4:0]               right_length,
    input  logic                     entry_mode,
    // configuration
    input  logic [4:0]               map_count,
    input  logic [7:0]               timeout_ticks,
    // table access
    output ksr_pkg::tbl_cmd_t        cmd,
    output logic [EW-1:0]            wr_entry,
    output logic [LW-1:0]            wr_lpos,
    output logic [RW-1:0]            wr_rpos,
    output logic [7:0]               wr_byte,
    output logic [LLW-1:0]           wr_llen,
    output logic [RLW-1:0]           wr_rlen,
    output logic                     wr_mode,
    output logic [EW-1:0]            rd_entry,
    output logic [RW-1:0]            rd_rpos,
    input  logic [LEFT_MAX-1:0][7:0] left_row,
    input  logic [LLW-1:0]           hdr_llen,
    input  logic [RLW-1:0]           hdr_rlen,
    input  logic                     hdr_mode,
    input  logic [7:0]               right_byte,
    // result requests
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_key,
    output logic                     m_last
);

    localparam int CW  = $clog2(MAP_ENTRIES + 1);
    localparam int PW  = $clog2(LEFT_MAX + 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FLUSH,
        ST_RIGHT_RD,
        ST_RIGHT_LD
    } state_t;

    state_t           state_reg, state_next;
    logic [PW-1:0]    pc_reg, pc_next;
    logic [7:0]       wt_reg, wt_next;
    logic             prefix_reg, prefix_next;
    logic             m_valid_reg, m_valid_next;

    logic             kmode_reg, kmode_next;
    logic [CW-1:0]    scan_reg, scan_next;
    logic [PW-1:0]    fk_reg, fk_next;
    logic [RW-1:0]    rk_reg, rk_next;
    logic [EW-1:0]    match_reg, match_next;
    logic [RLW-1:0]   rlen_reg, rlen_next;
    logic [7:0]       m_key_reg, m_key_next;
    logic             m_last_reg, m_last_next;

    // held keys; the extra slot takes the key that overflows a full buffer
    logic [7:0]       pend_reg [LEFT_MAX+1];
    logic             pend_we;

    logic             accept;
    logic             out_free;
    logic [CW-1:0]    limit;
    logic [7:0]       wt_inc;
    logic             entry_ok;
    logic [LEFT_MAX-1:0] byte_ok;
    logic             prefix_hit;
    logic             exact_hit;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Live entry count, capped at the table depth
    assign limit = (32'(map_count) > MAP_ENTRIES) ? CW'(MAP_ENTRIES) : CW'(map_count);

    // Saturating tick count
    assign wt_inc = (wt_reg == 8'hFF) ? wt_reg : wt_reg + 8'd1;

    assign entry_ok = (32'(entry_index) < MAP_ENTRIES);

    // Compare the held keys against the left row just read
    always_comb begin
        for (int j = 0; j < LEFT_MAX; j++) begin
            byte_ok[j] = (PW'(j) >= pc_reg) || (left_row[j] == pend_reg[j]);
        end
    end

    assign prefix_hit = (hdr_mode == kmode_reg) && (PW'(hdr_llen) >= pc_reg) && (&byte_ok);
    assign exact_hit  = prefix_hit && (PW'(hdr_llen) == pc_reg);

    // Table write data from the request, with the lengths capped at the side maximums
    assign wr_entry = EW'(entry_index);
    assign wr_lpos  = LW'(byte_position);
    assign wr_rpos  = RW'(byte_position);
    assign wr_byte  = table_byte;
    assign wr_llen  = (32'(left_length) > LEFT_MAX) ? LLW'(LEFT_MAX) : LLW'(left_length);
    assign wr_rlen  = (32'(right_length) > RIGHT_MAX) ? RLW'(RIGHT_MAX) : RLW'(right_length);
    assign wr_mode  = entry_mode;
    assign rd_rpos  = rk_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        wt_next      = wt_reg;
        prefix_next  = prefix_reg;
        kmode_next   = kmode_reg;
        scan_next    = scan_reg;
        fk_next      = fk_reg;
        rk_next      = rk_reg;
        match_next   = match_reg;
        rlen_next    = rlen_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_key_next   = m_key_reg;
        m_last_next  = m_last_reg;
        pend_we      = 1'b0;
        cmd          = '0;
        rd_entry     = match_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (op)
                        ksr_pkg::OP_BYTE: begin
                            cmd.we_left  = entry_ok && !byte_is_right &&
                                           (32'(byte_position) < LEFT_MAX);
                            cmd.we_right = entry_ok && byte_is_right &&
                                           (32'(byte_position) < RIGHT_MAX);
                        end
                        ksr_pkg::OP_HDR: begin
                            cmd.we_hdr = entry_ok;
                        end
                        ksr_pkg::OP_TICK: begin
                            // count only while keys are held
                            if (pc_reg != '0) begin
                                if (wt_inc > timeout_ticks) begin
                                    wt_next    = '0;
                                    fk_next    = '0;
                                    state_next = ST_FLUSH;
                                end else begin
                                    wt_next = wt_inc;
                                end
                            end
                        end
                        ksr_pkg::OP_KEY: begin
                            wt_next    = '0;
                            pend_we    = 1'b1;
                            pc_next    = pc_reg + PW'(1);
                            kmode_next = key_mode;
                            if (pc_reg == PW'(LEFT_MAX) || limit == '0) begin
                                fk_next    = '0;
                                state_next = ST_FLUSH;
                            end else begin
                                scan_next   = '0;
                                prefix_next = 1'b0;
                                state_next  = ST_SCAN_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN_RD: begin
                cmd.rd_scan = 1'b1;
                rd_entry    = EW'(scan_reg);
                state_next  = ST_SCAN_CMP;
            end

            ST_SCAN_CMP: begin
                if (exact_hit) begin
                    // first exact match wins: drop the held keys, play the right side
                    match_next = EW'(scan_reg);
                    rlen_next  = hdr_rlen;
                    rk_next    = '0;
                    pc_next    = '0;
                    state_next = (hdr_rlen == '0) ? ST_IDLE : ST_RIGHT_RD;
                end else begin
                    if (prefix_hit) begin
                        prefix_next = 1'b1;
                    end
                    if (scan_reg + CW'(1) < limit) begin
                        scan_next  = scan_reg + CW'(1);
                        state_next = ST_SCAN_RD;
                    end else if (prefix_hit || prefix_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        fk_next    = '0;
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_key_next   = pend_reg[fk_reg[LLW-1:0]];
                    m_last_next  = (fk_reg + PW'(1) == pc_reg);
                    if (fk_reg + PW'(1) == pc_reg) begin
                        pc_next    = '0;
                        state_next = ST_IDLE;
                    end else begin
                        fk_next = fk_reg + PW'(1);
                    end
                end
            end

            ST_RIGHT_RD: begin
                cmd.rd_right = 1'b1;
                state_next   = ST_RIGHT_LD;
            end

            ST_RIGHT_LD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_key_next   = right_byte;
                    m_last_next  = (RLW'(rk_reg) + RLW'(1) == rlen_reg);
                    if (RLW'(rk_reg) + RLW'(1) == rlen_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        rk_next    = rk_reg + RW'(1);
                        state_next = ST_RIGHT_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            wt_reg      <= '0;
            prefix_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            wt_reg      <= wt_next;
            prefix_reg  <= prefix_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kmode_reg  <= kmode_next;
        scan_reg   <= scan_next;
        fk_reg     <= fk_next;
        rk_reg     <= rk_next;
        match_reg  <= match_next;
        rlen_reg   <= rlen_next;
        m_key_reg  <= m_key_next;
        m_last_reg <= m_last_next;
    end

    // Append the new key to the pending buffer
    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_reg[pc_reg[LLW-1:0]] <= key_value;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_key   = m_key_reg;
    assign m_last  = m_last_reg;

    // Between requests the buffer never holds more than a full left side
    a_pc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (pc_reg <= PW'(LEFT_MAX)))
        else $error("pending count above left side maximum while idle");

    // The tick count only runs while keys are held
    a_wt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && pc_reg == '0) |-> (wt_reg == '0))
        else $error("tick count running with an empty buffer");

    // Scan address stays within the live entries
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN_RD) |-> (scan_reg < limit))
        else $error("scan beyond live entry count");

    // A right-side byte is only loaded after its read was issued
    a_right_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RIGHT_LD) |->
            ($past(state_reg) == ST_RIGHT_RD || $past(state_reg) == ST_RIGHT_LD))
        else $error("right-side load without a read");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the key sequence remapper: table, key, tick and config traffic.
`timescale 1ns / 1ps

module tb;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 80;     // longest scan with no result, plus margin
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 20;
    localparam int N_ENTRIES     = 16;
    localparam int N_LEFT        = 8;
    localparam int N_RIGHT       = 24;

    // Directed keys sit apart from the random left-side alphabet
    localparam logic [7:0] KEY_A     = 8'h41;
    localparam logic [7:0] KEY_B     = 8'h42;
    localparam logic [7:0] KEY_C     = 8'h43;
    localparam logic [7:0] KEY_STRAY = 8'h7A;

    localparam int PH_MAP [6] = '{16, 5, 31, 0, 12, 16};
    localparam int PH_TO  [6] = '{2, 1, 255, 7, 60, 3};

    // Tracks the table, the held keys and the keys due on the result side
    class remap_scoreboard;
        typedef struct packed {
            logic [7:0] key;
            logic       last;
        } key_out_t;

        logic [7:0] left_tab  [N_ENTRIES * N_LEFT];
        logic [7:0] right_tab [N_ENTRIES * N_RIGHT];
        logic [3:0] left_len  [N_ENTRIES];
        logic [4:0] right_len [N_ENTRIES];
        logic       mode_tab  [N_ENTRIES];
        logic [7:0] held      [N_LEFT];
        int         held_n;
        logic [7:0] wait_cnt;
        logic [4:0] map_count;
        logic [7:0] timeout;
        key_out_t   due_keys [$];
        int         errors;

        function new();
            foreach (left_tab[i]) left_tab[i] = '0;
            foreach (right_tab[i]) right_tab[i] = '0;
            foreach (left_len[i]) begin
                left_len[i]  = '0;
                right_len[i] = '0;
                mode_tab[i]  = 1'b0;
            end
            foreach (held[i]) held[i] = '0;
            held_n    = 0;
            wait_cnt  = '0;
            map_count = '0;
            timeout   = ksr_pkg::DEFAULT_TIMEOUT;
            errors    = 0;
        endfunction

        function void write_reg(logic idx, logic [7:0] value);
            if (idx == ksr_pkg::REG_MAP_COUNT) begin
                map_count = value[4:0];
            end else begin
                timeout = value;
            end
        endfunction

        function int live_entries();
            return (map_count > N_ENTRIES) ? N_ENTRIES : int'(map_count);
        endfunction

        // Work out the keys that one accepted request hands on
        function void predict_keys(ksr_pkg::op_t op, logic [39:0] d);
            logic [7:0] k;
            logic [7:0] tbyte;
            logic       kmode;
            logic       is_right;
            logic       emode;
            int         entry;
            int         pos;
            int         llen;
            int         rlen;
            int         lim;
            bit         prefix;
            bit         hit;
            bit         same;
            logic [7:0] run [$];
            k        = d[7:0];
            kmode    = d[8];
            entry    = int'(d[12:9]);
            pos      = int'(d[17:13]);
            is_right = d[18];
            tbyte    = d[26:19];
            llen     = int'(d[30:27]);
            rlen     = int'(d[35:31]);
            emode    = d[36];
            case (op)
                ksr_pkg::OP_BYTE: begin
                    if (is_right) begin
                        if (pos < N_RIGHT) right_tab[entry * N_RIGHT + pos] = tbyte;
                    end else if (pos < N_LEFT) begin
                        left_tab[entry * N_LEFT + pos] = tbyte;
                    end
                end
                ksr_pkg::OP_HDR: begin
                    left_len[entry]  = 4'((llen > N_LEFT) ? N_LEFT : llen);
                    right_len[entry] = 5'((rlen > N_RIGHT) ? N_RIGHT : rlen);
                    mode_tab[entry]  = emode;
                end
                ksr_pkg::OP_TICK: begin
                    // age the held keys, flush once past the limit
                    if (held_n != 0) begin
                        if (wait_cnt != 8'hFF) wait_cnt++;
                        if (wait_cnt > timeout) begin
                            for (int i = 0; i < held_n; i++) run.push_back(held[i]);
                            held_n   = 0;
                            wait_cnt = '0;
                        end
                    end
                end
                default: begin
                    wait_cnt = '0;
                    if (held_n >= N_LEFT) begin
                        // full buffer: flush it and the new key
                        for (int i = 0; i < N_LEFT; i++) run.push_back(held[i]);
                        run.push_back(k);
                        held_n = 0;
                    end else begin
                        held[held_n] = k;
                        held_n++;
                        lim    = live_entries();
                        prefix = 1'b0;
                        hit    = 1'b0;
                        // first exact match in table order wins
                        for (int i = 0; i < lim && !hit; i++) begin
                            if (mode_tab[i] == kmode && left_len[i] >= held_n) begin
                                same = 1'b1;
                                for (int j = 0; j < held_n; j++) begin
                                    if (left_tab[i * N_LEFT + j] != held[j]) same = 1'b0;
                                end
                                if (same && left_len[i] == held_n) begin
                                    hit = 1'b1;
                                    for (int j = 0; j < right_len[i]; j++) begin
                                        run.push_back(right_tab[i * N_RIGHT + j]);
                                    end
                                    held_n = 0;
                                end else if (same) begin
                                    prefix = 1'b1;
                                end
                            end
                        end
                        // no mapping can still match: hand on the keys as typed
                        if (!hit && !prefix) begin
                            for (int i = 0; i < held_n; i++) run.push_back(held[i]);
                            held_n = 0;
                        end
                    end
                end
            endcase
            foreach (run[i]) due_keys.push_back('{run[i], i == run.size() - 1});
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one result request with the oldest key due
        task check_key(logic [7:0] k, logic last);
            key_out_t want;
            if (due_keys.size() == 0) begin
                report($sformatf("key %02h (last %0b) with none due", k, last));
                return;
            end
            want = due_keys.pop_front();
            if (k !== want.key) report($sformatf("key %02h, due %02h", k, want.key));
            if (last !== want.last) report($sformatf("last %0b, due %0b", last, want.last));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [0:0]  cfg_addr;
    logic [7:0]  cfg_wdata;

    remap_scoreboard sb;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        rx_hold_req;
    logic        rx_hold_done;
    int          cycle_count = 0;
    // leading bytes of each side written while filling the table
    int          left_fill  [N_ENTRIES];
    int          right_fill [N_ENTRIES];

    key_sequence_remapper u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Check every accepted result request
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_key(m_tdata, m_tlast);
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        m_tready     = 1'b0;
        rx_hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req && !rx_hold_done) begin
                m_tready     <= 1'b0;
                rx_hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Random fill for the fields that a request does not use
    function automatic logic [39:0] noise();
        logic [39:0] d;
        d = {8'h00, $urandom};
        d[36:32] = 5'($urandom);
        return d;
    endfunction

    function automatic logic [7:0] pool_key();
        return 8'($urandom_range(8'h64, 8'h61));
    endfunction

    function automatic logic [3:0] rand_left_len();
        return ($urandom_range(9) < 7) ? 4'($urandom_range(3, 1)) : 4'($urandom_range(15));
    endfunction

    function automatic logic [4:0] rand_right_len();
        return ($urandom_range(9) < 7) ? 5'($urandom_range(4)) : 5'($urandom_range(31));
    endfunction

    // Offer one input request, hold it until accepted
    task automatic send_item(ksr_pkg::op_t op, logic [39:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        sb.predict_keys(op, d);
    endtask

    task automatic press(logic [7:0] k, logic m);
        logic [39:0] d;
        d      = noise();
        d[7:0] = k;
        d[8]   = m;
        send_item(ksr_pkg::OP_KEY, d);
    endtask

    task automatic tick();
        send_item(ksr_pkg::OP_TICK, noise());
    endtask

    task automatic put_byte(logic [3:0] e, logic side, logic [4:0] pos, logic [7:0] b);
        logic [39:0] d;
        d        = noise();
        d[12:9]  = e;
        d[17:13] = pos;
        d[18]    = side;
        d[26:19] = b;
        send_item(ksr_pkg::OP_BYTE, d);
    endtask

    task automatic put_header(logic [3:0] e, logic [3:0] l, logic [4:0] r, logic m);
        logic [39:0] d;
        d        = noise();
        d[12:9]  = e;
        d[30:27] = l;
        d[35:31] = r;
        d[36]    = m;
        send_item(ksr_pkg::OP_HDR, d);
    endtask

    task automatic write_cfg(logic idx, logic [7:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every due key, then let a silent scan finish
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.due_keys.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [3:0] ll;
        logic [4:0] rl;
        logic       md;
        logic       side;
        logic [7:0] b;
        int         n;
        int         r;
        int         e;
        int         cut;
        int         t;
        int         lim;
        int         to;
        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ksr_pkg::OP_KEY;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        rx_hold_req  = 1'b0;
        tx_idle_pct  = 24;
        rx_idle_pct  = 61;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fill every header and the bytes its lengths reach; entries 0 to 5 are directed
        for (int i = 0; i < N_ENTRIES; i++) begin
            case (i)
                0:       begin ll = 4'd2;  rl = 5'd3;  md = 1'b0; end
                1:       begin ll = 4'd3;  rl = 5'd5;  md = 1'b0; end
                2:       begin ll = 4'd1;  rl = 5'd0;  md = 1'b1; end
                3:       begin ll = 4'd0;  rl = 5'd4;  md = 1'b0; end
                4:       begin ll = 4'd15; rl = 5'd31; md = 1'b0; end
                5:       begin ll = 4'd2;  rl = 5'd24; md = 1'b0; end
                default: begin ll = rand_left_len(); rl = rand_right_len(); md = 1'($urandom); end
            endcase
            put_header(4'(i), ll, rl, md);
            left_fill[i]  = (int'(ll) > N_LEFT) ? N_LEFT : int'(ll);
            right_fill[i] = (int'(rl) > N_RIGHT) ? N_RIGHT : int'(rl);
            for (int j = 0; j < left_fill[i]; j++) begin
                case (i)
                    0, 1:    b = (j == 0) ? KEY_A : (j == 1) ? KEY_B : KEY_C;
                    2:       b = KEY_A;
                    4:       b = KEY_C;
                    5:       b = j[0] ? 8'hFF : 8'h00;
                    default: b = pool_key();
                endcase
                put_byte(4'(i), 1'b0, 5'(j), b);
            end
            for (int j = 0; j < right_fill[i]; j++) begin
                b = (i == 5) ? (j[0] ? 8'hFF : 8'h00) : 8'($urandom);
                put_byte(4'(i), 1'b1, 5'(j), b);
            end
        end
        drain();

        // Directed: match, timeout flush, stray key, empty right side, longest runs
        write_cfg(ksr_pkg::REG_MAP_COUNT, 8'd16);
        write_cfg(ksr_pkg::REG_TIMEOUT, 8'd3);
        press(KEY_A, 1'b0);
        press(KEY_B, 1'b0);
        press(KEY_A, 1'b0);
        repeat (4) tick();
        press(KEY_STRAY, 1'b0);
        press(KEY_A, 1'b1);
        repeat (N_LEFT) press(KEY_C, 1'b0);
        press(8'h00, 1'b0);
        press(8'hFF, 1'b0);
        tick();
        drain();
        // longest timeout: held key waits for the next press
        write_cfg(ksr_pkg::REG_TIMEOUT, 8'd255);
        press(KEY_A, 1'b0);
        repeat (3) tick();
        press(KEY_STRAY, 1'b0);
        drain();
        // zero timeout: first tick flushes
        write_cfg(ksr_pkg::REG_TIMEOUT, 8'd0);
        press(KEY_A, 1'b0);
        tick();

        // Random phases over several settings
        for (int p = 0; p < 6; p++) begin
            drain();
            write_cfg(ksr_pkg::REG_MAP_COUNT, 8'(PH_MAP[p]));
            write_cfg(ksr_pkg::REG_TIMEOUT, 8'(PH_TO[p]));
            if (p < 2) begin
                tx_idle_pct = 24;
                rx_idle_pct = 61;
            end else if (p < 4) begin
                tx_idle_pct = 61;
                rx_idle_pct = 24;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 0) rx_hold_req = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS) begin
                lim = sb.live_entries();
                to  = int'(sb.timeout);
                r   = $urandom_range(99);
                if (r < 60 && lim > 0) begin
                    // type a live left side, sometimes cut short, ticks mixed in
                    e   = $urandom_range(lim - 1);
                    cut = (sb.left_len[e] == 0) ? 1 : int'(sb.left_len[e]);
                    if ($urandom_range(3) == 0) cut = $urandom_range(cut, 1);
                    for (int j = 0; j < cut; j++) begin
                        if ($urandom_range(5) == 0) tick();
                        press(sb.left_tab[e * N_LEFT + j], sb.mode_tab[e]);
                    end
                    n += cut;
                    if ($urandom_range(2) == 0) begin
                        t = $urandom_range((to > 8) ? 3 : to + 2);
                        repeat (t) tick();
                        n += t;
                    end
                end else begin
                    r = $urandom_range(99);
                    if (r < 40) begin
                        press($urandom_range(1) ? pool_key() : 8'($urandom), 1'($urandom));
                    end else if (r < 70) begin
                        tick();
                    end else if (r < 88) begin
                        side = 1'($urandom);
                        put_byte(4'($urandom), side, 5'($urandom),
                                 side ? 8'($urandom) : pool_key());
                    end else if (r < 97) begin
                        // keep the lengths within the bytes written during the fill
                        e  = $urandom_range(N_ENTRIES - 1);
                        ll = rand_left_len();
                        rl = rand_right_len();
                        if (left_fill[e] < N_LEFT && int'(ll) > left_fill[e]) begin
                            ll = 4'(left_fill[e]);
                        end
                        if (right_fill[e] < N_RIGHT && int'(rl) > right_fill[e]) begin
                            rl = 5'(right_fill[e]);
                        end
                        put_header(4'(e), ll, rl, 1'($urandom));
                    end else begin
                        // long tick burst so a timeout below 100 expires too
                        t = (to < 100) ? to + 1 : 4;
                        repeat (t) tick();
                        n += t - 1;
                    end
                    n++;
                end
            end
        end
        drain();

        if (sb.due_keys.size() != 0) sb.report("keys still due at the end");
        if (sb.errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
